// ----- hdl/pdac_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdac_pkg
// Shared types and constants for the packet drop admission control block.
// ----------------------------------------------------------------------------
package pdac_pkg;

  localparam int PORT_W      = 3;
  localparam int SIZE_W      = 13;
  localparam int DRAW_W      = 16;
  localparam int OCC_W       = 13;
  localparam int ACTION_W    = 2;
  localparam int CAP_W       = 13;
  localparam int THR_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_USER_W   = 2;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 16;

  // command codes
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_DEPART = 1'b1;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_FWD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DROP   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DEPART = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_THRESHOLD = 1'd1;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd1024;
  localparam logic [THR_W-1:0] THR_RESET = 16'd0;

  typedef struct packed {
    logic [DRAW_W-1:0] random_draw;
    logic [SIZE_W-1:0] packet_size;
    logic              is_tail;
    logic              is_head;
    logic [PORT_W-1:0] route_port;
    logic [PORT_W-1:0] in_port;
    logic              command;
  } item_t;

  typedef struct packed {
    logic [OCC_W-1:0]    port_occupancy;
    logic [PORT_W-1:0]   dest_port;
    logic [ACTION_W-1:0] action;
  } result_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage : pdac_pkg
`default_nettype wire

// ----- hdl/pdac_in_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdac_in_reg
// Input register: captures one flit transaction and holds it until the
// decision stage consumes it.
// ----------------------------------------------------------------------------
module pdac_in_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire pdac_pkg::item_t in_item,
  input  wire logic           take,      // decision stage consumes the item
  output logic                item_valid,
  output pdac_pkg::item_t     item
);
  import pdac_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule : pdac_in_reg
`default_nettype wire

// ----- hdl/pdac_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdac_core
// Admission decision: per-input packet state, per-output occupancy counters
// and the configuration registers. One item is resolved per fire cycle.
// ----------------------------------------------------------------------------
module pdac_core #(
  parameter int NUM_INPUTS   = 8,
  parameter int NUM_OUTPUTS  = 8,
  parameter int MAX_CAPACITY = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pdac_pkg::cfg_wr_t cfg_wr,
  input  wire logic              fire,
  input  wire pdac_pkg::item_t   item,
  output pdac_pkg::result_t      result
);
  import pdac_pkg::*;

  localparam int IN_IDX_W  = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int OUT_IDX_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int FILL_W    = $clog2(MAX_CAPACITY + 1);
  localparam int SUM_W     = ((FILL_W > SIZE_W) ? FILL_W : SIZE_W) + 1;

  logic [CAP_W-1:0]  cap_r;
  logic [THR_W-1:0]  thr_r;
  logic              busy_r  [NUM_INPUTS];
  logic              drop_r  [NUM_INPUTS];
  logic [PORT_W-1:0] bound_r [NUM_INPUTS];
  logic [FILL_W-1:0] fill_r  [NUM_OUTPUTS];

  logic [IN_IDX_W-1:0]  in_idx;
  logic [OUT_IDX_W-1:0] out_idx;
  logic                 arrive, depart, ip_ok, busy, open_pkt, cont_pkt, cur_drop;
  logic [PORT_W-1:0]    tgt;
  logic                 tgt_ok, over, refuse, fwd, inc, dec;
  logic [FILL_W-1:0]    fill_cur, fill_nxt;
  logic [SUM_W-1:0]     need;
  logic                 busy_nxt, drop_nxt;

  always_comb begin
    depart   = (item.command == CMD_DEPART);
    arrive   = !depart;
    in_idx   = IN_IDX_W'(item.in_port);
    ip_ok    = (32'(item.in_port) < NUM_INPUTS);
    busy     = ip_ok && busy_r[in_idx];
    cur_drop = ip_ok && drop_r[in_idx];
    open_pkt = arrive && ip_ok && !busy;
    cont_pkt = arrive && ip_ok && busy;

    // an open packet sticks to the port its head was routed to
    tgt      = cont_pkt ? bound_r[in_idx] : item.route_port;
    tgt_ok   = (32'(tgt) < NUM_OUTPUTS);
    out_idx  = OUT_IDX_W'(tgt);
    fill_cur = tgt_ok ? fill_r[out_idx] : '0;

    need   = SUM_W'(item.packet_size) + SUM_W'(fill_cur);
    over   = (need > SUM_W'(cap_r));
    refuse = !tgt_ok || over || (item.random_draw < thr_r);

    fwd = tgt_ok && ((open_pkt && !refuse) || (cont_pkt && !cur_drop));
    inc = fwd && (fill_cur < FILL_W'(MAX_CAPACITY));
    dec = depart && tgt_ok && (fill_cur != '0);

    fill_nxt = fill_cur;
    if (inc) begin
      fill_nxt = fill_cur + FILL_W'(1);
    end else if (dec) begin
      fill_nxt = fill_cur - FILL_W'(1);
    end

    busy_nxt = busy;
    drop_nxt = cur_drop;
    if (open_pkt) begin
      busy_nxt = !item.is_tail;
      drop_nxt = refuse && !item.is_tail;
    end else if (cont_pkt && item.is_tail) begin
      busy_nxt = 1'b0;
      drop_nxt = 1'b0;
    end

    if (depart) begin
      result.action = ACT_DEPART;
    end else if (fwd) begin
      result.action = ACT_FWD;
    end else begin
      result.action = ACT_DROP;
    end
    result.dest_port      = tgt;
    result.port_occupancy = OCC_W'(fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      thr_r <= THR_RESET;
      for (int i = 0; i < NUM_INPUTS; i++) begin
        busy_r[i]  <= 1'b0;
        drop_r[i]  <= 1'b0;
        bound_r[i] <= '0;
      end
      for (int j = 0; j < NUM_OUTPUTS; j++) begin
        fill_r[j] <= '0;
      end
    end else begin
      if (cfg_wr.valid) begin
        case (cfg_wr.index)
          REG_QUEUE_CAPACITY: cap_r <= CAP_W'(cfg_wr.data);
          REG_DROP_THRESHOLD: thr_r <= THR_W'(cfg_wr.data);
          default: ;
        endcase
      end
      if (fire) begin
        if (open_pkt || cont_pkt) begin
          busy_r[in_idx] <= busy_nxt;
          drop_r[in_idx] <= drop_nxt;
        end
        if (open_pkt) begin
          bound_r[in_idx] <= item.route_port;
        end
        if (tgt_ok) begin
          fill_r[out_idx] <= fill_nxt;
        end
      end
    end
  end

endmodule : pdac_core
`default_nettype wire

// ----- hdl/pdac_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdac_out_reg
// Result register: holds one decision until the downstream takes it.
// ----------------------------------------------------------------------------
module pdac_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load_valid,
  input  wire pdac_pkg::result_t load_result,
  output logic                   free,       // can load this cycle
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pdac_pkg::result_t      out_result
);
  import pdac_pkg::*;

  logic    valid_r, valid_nxt;
  result_t result_r;

  assign free       = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load_valid) begin
      result_r <= load_result;
    end
  end

endmodule : pdac_out_reg
`default_nettype wire

// ----- hdl/packet_drop_admission_control.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packet_drop_admission_control
// Packet-level tail-drop admission for router input ports.
// ----------------------------------------------------------------------------
// Takes one flit or departure transaction per clock and returns exactly one
// result per transaction, in order, on out_tvalid via the input register,
// then the result register. Throughput is one item every cycle while
// out_tready is high: the per-port state lookup, admission compare and
// occupancy update all complete combinationally between the two registers,
// so back-to-back items on the same port see each other's effects with no
// stall. in_tready drops only when the result register is full and not being
// drained. Configuration writes are accepted every cycle and should be issued
// while no item is in flight.
// ----------------------------------------------------------------------------
module packet_drop_admission_control #(
  parameter int NUM_INPUTS   = 8,
  parameter int NUM_OUTPUTS  = 8,
  parameter int MAX_CAPACITY = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [2:0] in_port, [5:3] route_port, [18:6] packet_size, [34:19] random_draw
  input  wire logic [pdac_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] command, [1] is_head
  input  wire logic [pdac_pkg::IN_USER_W-1:0]      in_tuser,
  input  wire logic                                in_tlast,   // is_tail
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [2:0] dest_port, [15:3] port_occupancy
  output logic [pdac_pkg::OUT_DATA_W-1:0]          out_tdata,
  // [1:0] action
  output logic [pdac_pkg::ACTION_W-1:0]            out_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pdac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pdac_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pdac_pkg::*;

  item_t   in_item, item;
  result_t result, out_result;
  cfg_wr_t cfg_wr;
  logic    item_valid, out_free, fire;

  always_comb begin
    in_item.command     = in_tuser[0];
    in_item.is_head     = in_tuser[1];
    in_item.is_tail     = in_tlast;
    in_item.in_port     = in_tdata[2:0];
    in_item.route_port  = in_tdata[5:3];
    in_item.packet_size = in_tdata[18:6];
    in_item.random_draw = in_tdata[34:19];
  end

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign fire = item_valid && out_free;

  pdac_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (out_free),
    .item_valid (item_valid),
    .item       (item)
  );

  pdac_core #(
    .NUM_INPUTS   (NUM_INPUTS),
    .NUM_OUTPUTS  (NUM_OUTPUTS),
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  pdac_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_valid  (item_valid),
    .load_result (result),
    .free        (out_free),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_result  (out_result)
  );

  assign out_tdata = {out_result.port_occupancy, out_result.dest_port};
  assign out_tuser = out_result.action;

endmodule : packet_drop_admission_control
`default_nettype wire

// ----- hdl/pdac_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdac_checker
// Port-level checks for the admission control block, bound to the top level.
// ----------------------------------------------------------------------------
module pdac_checker #(
  parameter int NUM_OUTPUTS  = 8,
  parameter int MAX_CAPACITY = 4096
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [pdac_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [pdac_pkg::ACTION_W-1:0]   out_tuser
);
  import pdac_pkg::*;

  // no result can appear without an earlier accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result appeared without an accepted transaction");

  a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ACT_FWD || out_tuser == ACT_DROP ||
                    out_tuser == ACT_DEPART))
    else $error("undefined action code");

  // unrouted ports carry no occupancy
  a_unrouted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (32'(out_tdata[2:0]) >= NUM_OUTPUTS)) |->
      (out_tdata[15:3] == '0) && (out_tuser != ACT_FWD))
    else $error("occupancy or forward on a nonexistent port");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((MAX_CAPACITY > 8191) ||
                    (32'(out_tdata[15:3]) <= MAX_CAPACITY)))
    else $error("occupancy above maximum capacity");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
                                      $stable(out_tuser)))
    else $error("stalled result changed");

endmodule : pdac_checker

bind packet_drop_admission_control pdac_checker #(
  .NUM_OUTPUTS  (NUM_OUTPUTS),
  .MAX_CAPACITY (MAX_CAPACITY)
) u_pdac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for packet_drop_admission_control. A short directed
// table covers framing corner cases, capacity and threshold extremes and
// departure underflow. Random packet traffic runs under several limit
// settings, and one long packet runs on a single input to the end.
// Every result is checked against an in-bench admission model or a table entry.
// ----------------------------------------------------------------------------
module testbench;
  import pdac_pkg::*;

  localparam int N_PORTS        = 8;
  localparam int OCC_MAX        = 4096;
  localparam int STALL_LIMIT    = 3000;
  localparam int HOLD_CYCLES    = 200;
  localparam int N_PHASES       = 5;
  localparam int RAND_PER_PHASE = 200;
  localparam int BURST_FLITS    = 64;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_DATA_W-1:0] cap_v;
    logic [CFG_DATA_W-1:0] thr_v;
    item_t                 flit;
    bit                    known;
    result_t               want;
  } row_t;

  typedef struct {
    bit      known;
    result_t want;
  } typed_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [ACTION_W-1:0]   out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // admission model state
  bit               open_pkt [N_PORTS];
  bit               discard  [N_PORTS];
  logic [PORT_W-1:0] pkt_port [N_PORTS];
  logic [OCC_W-1:0] occ      [N_PORTS];
  logic [CAP_W-1:0] cap_reg;
  logic [THR_W-1:0] thr_reg;

  result_t due_q[$];
  typed_t  typed_q[$];
  row_t    rows[$];
  int      n_in    = 0;
  int      n_out   = 0;
  int      errors  = 0;
  int      quiet   = 0;
  logic    calm;

  // both sides run gap-free over this window
  assign calm = (n_in >= 600) && (n_in < 850);

  packet_drop_admission_control dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void bump_occ(logic [PORT_W-1:0] p);
    if (int'(occ[p]) < OCC_MAX) occ[p] = occ[p] + 1'b1;
  endfunction

  function automatic result_t decide_flit(item_t f);
    result_t           r;
    logic [PORT_W-1:0] p;
    bit                refuse;
    if (f.command == CMD_DEPART) begin
      p = f.route_port;
      if (occ[p] != 0) occ[p] = occ[p] - 1'b1;
      r.action = ACT_DEPART;
    end else if (!open_pkt[f.in_port]) begin
      // idle input: any flit opens a packet, head mark or not
      p = f.route_port;
      refuse = (int'(f.packet_size) + int'(occ[p]) > int'(cap_reg)) ||
               (f.random_draw < thr_reg);
      pkt_port[f.in_port] = p;
      if (!f.is_tail) begin
        open_pkt[f.in_port] = 1'b1;
        discard[f.in_port]  = refuse;
      end
      if (!refuse) bump_occ(p);
      r.action = refuse ? ACT_DROP : ACT_FWD;
    end else begin
      p = pkt_port[f.in_port];
      if (discard[f.in_port]) begin
        r.action = ACT_DROP;
      end else begin
        bump_occ(p);
        r.action = ACT_FWD;
      end
      if (f.is_tail) begin
        open_pkt[f.in_port] = 1'b0;
        discard[f.in_port]  = 1'b0;
      end
    end
    r.dest_port      = p;
    r.port_occupancy = occ[p];
    return r;
  endfunction

  function automatic void cmp_field(string what, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want_v, got_v);
      errors++;
    end
  endfunction

  // scoreboard, model update and watchdog
  always @(posedge clk) begin : scoreboard
    result_t got;
    result_t want;
    item_t   f;
    typed_t  t;
    if (!rst_n) begin
      foreach (occ[i]) begin
        open_pkt[i] = 1'b0;
        discard[i]  = 1'b0;
        pkt_port[i] = '0;
        occ[i]      = '0;
      end
      cap_reg = CAP_RESET;
      thr_reg = THR_RESET;
    end else begin
      if (out_tvalid && out_tready) begin
        got.action         = out_tuser;
        got.dest_port      = out_tdata[2:0];
        got.port_occupancy = out_tdata[15:3];
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, got);
          errors++;
        end else begin
          want = due_q[0];
          due_q.delete(0);
          cmp_field("action", 16'(want.action), 16'(got.action));
          cmp_field("dest_port", 16'(want.dest_port), 16'(got.dest_port));
          cmp_field("port_occupancy", 16'(want.port_occupancy), 16'(got.port_occupancy));
        end
        n_out <= n_out + 1;
      end
      if (in_tvalid && in_tready) begin
        f.command     = in_tuser[0];
        f.is_head     = in_tuser[1];
        f.is_tail     = in_tlast;
        f.in_port     = in_tdata[2:0];
        f.route_port  = in_tdata[5:3];
        f.packet_size = in_tdata[18:6];
        f.random_draw = in_tdata[34:19];
        want = decide_flit(f);
        if (typed_q.size() != 0) begin
          t = typed_q[0];
          typed_q.delete(0);
          if (t.known) want = t.want;
        end
        due_q.insert(due_q.size(), want);
        n_in <= n_in + 1;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_QUEUE_CAPACITY) cap_reg = cfg_data[CAP_W-1:0];
        else if (cfg_index == REG_DROP_THRESHOLD) thr_reg = cfg_data[THR_W-1:0];
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // result sink: random backpressure plus one long hold-off
  initial begin : result_sink
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && n_in >= 300) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= calm || ($urandom_range(99) >= 32);
    end
  end

  task automatic send_flit(input item_t f);
    while (!calm && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({f.random_draw, f.packet_size, f.route_port, f.in_port});
    in_tuser  <= {f.is_head, f.command};
    in_tlast  <= f.is_tail;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // caller has already dropped in_tvalid
  task automatic wait_drained();
    @(posedge clk);
    while (n_in != n_out) @(posedge clk);
  endtask

  task automatic set_limits(input logic [CFG_DATA_W-1:0] cap_v,
                            input logic [CFG_DATA_W-1:0] thr_v);
    cfg_valid <= 1'b1;
    cfg_index <= REG_QUEUE_CAPACITY;
    cfg_data  <= cap_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_DROP_THRESHOLD;
    cfg_data  <= thr_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic row_t arrive(logic [PORT_W-1:0] ip, logic [PORT_W-1:0] rp,
                                  bit head, bit tail, logic [SIZE_W-1:0] size,
                                  logic [DRAW_W-1:0] draw, bit known,
                                  logic [ACTION_W-1:0] act, logic [PORT_W-1:0] port,
                                  logic [OCC_W-1:0] o);
    row_t r;
    r.is_cfg = 1'b0;
    r.cap_v  = '0;
    r.thr_v  = '0;
    r.flit   = '{command: CMD_ARRIVE, in_port: ip, route_port: rp, is_head: head,
                 is_tail: tail, packet_size: size, random_draw: draw};
    r.known  = known;
    r.want   = '{action: act, dest_port: port, port_occupancy: o};
    return r;
  endfunction

  function automatic row_t depart(logic [PORT_W-1:0] rp, bit known, logic [OCC_W-1:0] o);
    row_t r;
    r = arrive('0, rp, 1'b0, 1'b0, '0, '0, known, ACT_DEPART, rp, o);
    r.flit.command = CMD_DEPART;
    return r;
  endfunction

  function automatic row_t limits(logic [CFG_DATA_W-1:0] cap_v, logic [CFG_DATA_W-1:0] thr_v);
    row_t r;
    r = arrive('0, '0, 1'b0, 1'b0, '0, '0, 1'b0, ACT_FWD, '0, '0);
    r.is_cfg = 1'b1;
    r.cap_v  = cap_v;
    r.thr_v  = thr_v;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    rows.insert(rows.size(), r);
  endfunction

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] cap_set [N_PHASES];
    logic [CFG_DATA_W-1:0] thr_set [N_PHASES];
    logic [63:0]           noise;
    item_t                 f;
    typed_t                t;
    int                    left [N_PORTS];
    int                    ip;
    int                    pick;

    cap_set = '{16'd24, 16'd4096, 16'd1, 16'hE123, 16'd300};
    thr_set = '{16'd0, 16'd16384, 16'hFFFF, 16'd0, 16'd49152};
    foreach (left[i]) left[i] = 0;

    // reset limits: capacity 1024, threshold 0
    add_row(arrive(3'd0, 3'd3, 1, 1, 13'd1, 16'd0, 1, ACT_FWD, 3'd3, 13'd1));
    add_row(depart(3'd3, 1, 13'd0));
    add_row(depart(3'd3, 1, 13'd0));                // empty queue stays at zero
    add_row(arrive(3'd1, 3'd7, 1, 0, 13'd3, 16'hFFFF, 1, ACT_FWD, 3'd7, 13'd1));
    add_row(arrive(3'd1, 3'd0, 0, 0, 13'd0, 16'd0, 0, ACT_FWD, 3'd0, 13'd0));
    // head mark on a busy input continues the open packet
    add_row(arrive(3'd1, 3'd2, 1, 1, 13'd1, 16'd0, 0, ACT_FWD, 3'd0, 13'd0));
    // unmarked flit on idle input opens a packet that is too big
    add_row(arrive(3'd2, 3'd5, 0, 0, 13'd1025, 16'd0, 1, ACT_DROP, 3'd5, 13'd0));
    add_row(arrive(3'd2, 3'd1, 0, 1, 13'd9, 16'd0, 0, ACT_DROP, 3'd0, 13'd0));
    add_row(arrive(3'd3, 3'd5, 1, 1, 13'd1024, 16'd0, 1, ACT_FWD, 3'd5, 13'd1));
    add_row(arrive(3'd4, 3'd0, 1, 1, 13'd8191, 16'd0, 1, ACT_DROP, 3'd0, 13'd0));
    add_row(arrive(3'd5, 3'd6, 1, 1, 13'd0, 16'd0, 1, ACT_FWD, 3'd6, 13'd1));
    add_row(limits(16'd1, 16'hFFFF));
    add_row(arrive(3'd6, 3'd0, 1, 1, 13'd1, 16'hFFFF, 1, ACT_FWD, 3'd0, 13'd1));
    // refused single flit leaves the input idle
    add_row(arrive(3'd7, 3'd4, 1, 1, 13'd1, 16'hFFFE, 1, ACT_DROP, 3'd4, 13'd0));
    add_row(arrive(3'd7, 3'd4, 1, 1, 13'd1, 16'hFFFF, 1, ACT_FWD, 3'd4, 13'd1));
    add_row(limits(16'd0, 16'd0));
    add_row(arrive(3'd0, 3'd2, 1, 1, 13'd0, 16'd0, 1, ACT_FWD, 3'd2, 13'd1));
    add_row(arrive(3'd0, 3'd1, 1, 1, 13'd1, 16'd0, 1, ACT_DROP, 3'd1, 13'd0));
    // upper data bits are outside the capacity field
    add_row(limits(16'hFFFF, 16'd1));
    add_row(arrive(3'd1, 3'd1, 1, 1, 13'd8191, 16'd1, 1, ACT_FWD, 3'd1, 13'd1));
    add_row(arrive(3'd2, 3'd6, 1, 1, 13'd1, 16'd0, 1, ACT_DROP, 3'd6, 13'd1));
    add_row(limits(16'd4096, 16'h8000));
    add_row(arrive(3'd3, 3'd3, 1, 0, 13'd4096, 16'hFFFF, 1, ACT_FWD, 3'd3, 13'd1));
    add_row(depart(3'd3, 0, 13'd0));
    add_row(arrive(3'd3, 3'd0, 0, 1, 13'd0, 16'd0, 0, ACT_FWD, 3'd0, 13'd0));
    add_row(arrive(3'd4, 3'd7, 1, 1, 13'd1, 16'h7FFF, 1, ACT_DROP, 3'd7, 13'd3));
    add_row(depart(3'd7, 0, 13'd0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        in_tvalid <= 1'b0;
        wait_drained();
        set_limits(rows[i].cap_v, rows[i].thr_v);
      end else begin
        t.known = rows[i].known;
        t.want  = rows[i].want;
        typed_q.insert(typed_q.size(), t);
        send_flit(rows[i].flit);
      end
    end

    // random traffic: mostly well-formed packets, some departures and noise
    for (int phase = 0; phase < N_PHASES; phase++) begin
      in_tvalid <= 1'b0;
      wait_drained();
      set_limits(cap_set[phase], thr_set[phase]);
      repeat (RAND_PER_PHASE) begin
        noise = {$urandom, $urandom};
        f     = noise[$bits(item_t)-1:0];
        pick  = $urandom_range(99);
        if (pick < 35) begin
          f.command = CMD_DEPART;
        end else if (pick < 42) begin
          f.command = CMD_ARRIVE;
        end else begin
          ip = $urandom_range(N_PORTS - 1);
          f.command = CMD_ARRIVE;
          f.in_port = PORT_W'(ip);
          if (left[ip] == 0) begin
            left[ip] = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
            f.is_head = 1'b1;
            if ($urandom_range(19) != 0) f.packet_size = SIZE_W'(left[ip]);
          end else begin
            f.is_head = ($urandom_range(19) == 0);
          end
          f.is_tail = (left[ip] == 1);
          left[ip]--;
        end
        send_flit(f);
      end
    end

    // one long packet on input 0 routed to output 0
    in_tvalid <= 1'b0;
    wait_drained();
    set_limits(16'hFFFF, 16'd0);
    for (int k = 0; k < BURST_FLITS; k++) begin
      noise = {$urandom, $urandom};
      f     = noise[$bits(item_t)-1:0];
      f.command = CMD_ARRIVE;
      f.in_port = '0;
      f.is_head = (k == 1);
      // first flit is a lone tail that leaves input 0 idle whatever came before
      f.is_tail = (k == 0) || (k == BURST_FLITS - 1);
      if (k <= 1) begin
        f.route_port  = '0;
        f.packet_size = SIZE_W'(1);
      end
      send_flit(f);
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (due_q.size() != 0) begin
      $display("%0t: results missing, expected %0d more actual 0", $time, due_q.size());
      errors++;
    end
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
